### hdl/rme_pkg.sv
// Package: constants, types and tables for the rotation matrix engine.
package rme_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int FRAC_BITS_DEF    = 16;
   localparam int CORDIC_MAX_STEPS = 24;
   localparam int TURN_UNITS       = 92160;
   localparam int CW               = 34;
   localparam int ZW               = 33;

   // turn = r * 46603 + floor((17 * r + 22) / 45), the divide by a reciprocal
   localparam int SCALE_MUL   = 46603;
   localparam int SCALE_FIX   = 17;
   localparam int SCALE_BIAS  = 22;
   localparam int RECIP45     = 1491309;
   localparam int RECIP_SHIFT = 26;

   localparam logic [1:0] CMD_IDENT     = 2'd0;
   localparam logic [1:0] CMD_ROTATE    = 2'd1;
   localparam logic [1:0] CMD_TRANSFORM = 2'd2;

   localparam logic [CW-1:0] CORDIC_GAIN30 = CW'(652032874);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SCALE,
      ST_FOLD,
      ST_CORDIC,
      ST_ROUND,
      ST_BUILD,
      ST_MAC,
      ST_STORE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       clear;
      logic       start;
      logic [1:0] kind;
   } mac_ctrl_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] t;
      case (i)
         5'd0:    t = 32'd536870912;
         5'd1:    t = 32'd316933406;
         5'd2:    t = 32'd167458907;
         5'd3:    t = 32'd85004756;
         5'd4:    t = 32'd42667331;
         5'd5:    t = 32'd21354465;
         5'd6:    t = 32'd10679838;
         5'd7:    t = 32'd5340245;
         5'd8:    t = 32'd2670163;
         5'd9:    t = 32'd1335087;
         5'd10:   t = 32'd667544;
         5'd11:   t = 32'd333772;
         5'd12:   t = 32'd166886;
         5'd13:   t = 32'd83443;
         5'd14:   t = 32'd41722;
         5'd15:   t = 32'd20861;
         5'd16:   t = 32'd10430;
         5'd17:   t = 32'd5215;
         5'd18:   t = 32'd2608;
         5'd19:   t = 32'd1304;
         5'd20:   t = 32'd652;
         5'd21:   t = 32'd326;
         5'd22:   t = 32'd163;
         5'd23:   t = 32'd81;
         default: t = 32'd0;
      endcase
      return t;
   endfunction

endpackage

### hdl/rme_cordic.sv
// Iterative CORDIC: one micro-rotation per cycle on a shared add/shift datapath.
module rme_cordic
   import rme_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [ZW-1:0] z_start,
   output logic                 done,
   output logic signed [CW-1:0] x_out,
   output logic signed [CW-1:0] y_out
);

   localparam int NSTEP = (CORDIC_STEPS > CORDIC_MAX_STEPS) ? CORDIC_MAX_STEPS : CORDIC_STEPS;

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [4:0]           i_ff, i_in;
   logic                 busy_ff, busy_in;
   logic signed [CW-1:0] dx, dy;
   logic signed [ZW-1:0] at;

   always_comb begin
      dx = x_ff;
      dy = y_ff;
      dx = y_ff >>> i_ff;
      dy = x_ff >>> i_ff;
      at = $signed({1'b0, atan_turn(i_ff)});
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      i_in = i_ff;
      busy_in = busy_ff;
      if (start) begin
         x_in = $signed(CORDIC_GAIN30);
         y_in = '0;
         z_in = z_start;
         i_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[ZW-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         i_in = i_ff + 5'd1;
         if (i_ff == 5'(NSTEP - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         i_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         i_ff <= i_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done  = busy_ff && (i_ff == 5'(NSTEP - 1));
   assign x_out = x_in;
   assign y_out = y_in;

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (i_ff < 5'(NSTEP))) else $error("cordic step count overrun");
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      (done && !start) |=> !busy_ff) else $error("cordic still busy after done");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("cordic failed to start");

endmodule

### hdl/rme_mac.sv
// Shared multiply-accumulate unit: one product per cycle into a wide accumulator.
module rme_mac
   import rme_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  mac_ctrl_type       ctrl,
   input  logic signed [33:0] a,
   input  logic signed [33:0] b,
   output logic signed [69:0] acc
);

   logic signed [67:0] prod_ff, prod_in;
   logic               pv_ff, pv_in;
   logic signed [69:0] acc_ff, acc_in;

   always_comb begin
      prod_in = a * b;
      pv_in   = ctrl.start;
      acc_in  = acc_ff;
      if (ctrl.clear) acc_in = '0;
      else if (pv_ff) acc_in = acc_ff + 70'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) pv_ff <= 1'b0;
      else pv_ff <= pv_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

### hdl/axis_rotation_matrix_engine.sv
// Top level: stream wrapper, sequencer and matrix store of the rotation matrix engine.
//  channel | direction | fields
//  req     | in        | tdata: cmd, angle, axis, vec_x, vec_y, vec_z
//  rsp     | out       | tdata: out_x, out_y, out_z, saturated
// Identity, unused commands and rotations about axis 3: result registered in ST_OUT after accept.
// Transform: 3 rows on the shared MAC, each three products then ST_STORE; result registered in ST_OUT.
// Rotation: ST_REDUCE wraps the angle, then ST_SCALE, ST_FOLD, ST_CORDIC for the CORDIC steps,
// ST_ROUND, ST_BUILD, then 9 entries on the shared MAC, each three products then ST_STORE.
// reset is synchronous; the matrix returns to identity. rsp stalls hold the result
// register and req_tready stays low until it is taken, then rises in the cycle after.
module axis_rotation_matrix_engine
   import rme_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,  // cmd[1:0] angle[19:2] axis[21:20] vec_x vec_y vec_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata   // out_x[31:0] out_y out_z saturated[96]
);

   localparam int EW = FRAC_BITS + 2;

   state_type state_ff, state_in;
   logic [1:0]  cmd_ff, cmd_in, axis_ff, axis_in;
   logic signed [31:0] vec_ff [3];
   logic signed [EW-1:0] m_ff [9];
   logic signed [EW-1:0] nm_ff [9];
   logic signed [EW-1:0] r_ff [9];
   logic [52:0] num_ff, num_in;       // scale terms: [52:32] fraction numerator, [31:0] turn
   logic [41:0] qprod;
   logic [5:0]  cnt_ff, cnt_in;
   logic [3:0]  el_ff, el_in;
   logic [1:0]  k_ff, k_in;
   logic signed [18:0] ang_ff, ang_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic        neg_ff, neg_in;
   logic signed [CW-1:0] c_ff, s_ff;
   logic signed [31:0] out_ff [3];
   logic        sat_ff;
   logic        rv_ff;
   logic        cstart, cdone;
   logic signed [CW-1:0] cx, cy;
   mac_ctrl_type mctl;
   logic signed [33:0] ma, mb;
   logic signed [69:0] acc;
   logic [2:0]  wait_ff, wait_in;
   logic        acc_ok, c_ld;
   logic signed [69:0] rnd;
   logic signed [EW-1:0] ent;
   logic signed [31:0] ov;
   logic        ovf;

   rme_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock, .reset, .start(cstart), .z_start(z_ff), .done(cdone), .x_out(cx), .y_out(cy));

   rme_mac u_mac (.clock, .reset, .ctrl(mctl), .a(ma), .b(mb), .acc);

   function automatic logic signed [EW-1:0] sat_ent(input logic signed [69:0] v);
      if (v > 70'sd0 + ((70'sd1 <<< (FRAC_BITS + 1)) - 70'sd1))
         return {1'b0, {(EW-1){1'b1}}};
      if (v < -(70'sd1 <<< (FRAC_BITS + 1))) return {1'b1, {(EW-1){1'b0}}};
      return v[EW-1:0];
   endfunction

   wire [1:0] i_row = (el_ff >= 4'd6) ? 2'd2 : (el_ff >= 4'd3) ? 2'd1 : 2'd0;
   wire [1:0] j_col = 2'(el_ff - 4'(i_row) * 4'd3);

   always_comb begin
      rnd = (acc + (70'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      ent = sat_ent(rnd);
      ovf = 1'b0;
      if (rnd > 70'sd2147483647) begin ov = 32'h7fffffff; ovf = 1'b1; end
      else if (rnd < -70'sd2147483648) begin ov = 32'h80000000; ovf = 1'b1; end
      else ov = rnd[31:0];
      qprod = {21'd0, num_ff[52:32]} * 42'(RECIP45);
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff; axis_in = axis_ff;
      num_in = num_ff; cnt_in = cnt_ff; el_in = el_ff; k_in = k_ff;
      ang_in = ang_ff; z_in = z_ff; neg_in = neg_ff; wait_in = wait_ff;
      cstart = 1'b0; acc_ok = 1'b0; c_ld = 1'b0;
      mctl = '{clear: 1'b0, start: 1'b0, kind: 2'd0};
      ma = '0; mb = '0;
      req_tready = (state_ff == ST_IDLE) && !rv_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in  = req_tdata[1:0];
               axis_in = req_tdata[21:20];
               ang_in  = 19'(signed'(req_tdata[19:2]));
               el_in = '0; k_in = '0;
               mctl.clear = 1'b1;
               if (req_tdata[1:0] == CMD_ROTATE && req_tdata[21:20] != 2'd3)
                  state_in = ST_REDUCE;
               else if (req_tdata[1:0] == CMD_TRANSFORM) state_in = ST_MAC;
               else state_in = ST_OUT;
            end
         end
         ST_REDUCE: begin
            if (ang_ff < 0) ang_in = ang_ff + 19'sd92160;
            else if (ang_ff >= 19'sd92160) ang_in = ang_ff - 19'sd92160;
            else begin
               num_in[52:32] = 21'({4'd0, ang_ff[16:0]} * 21'(SCALE_FIX) + 21'(SCALE_BIAS));
               num_in[31:0]  = 32'({15'd0, ang_ff[16:0]} * 32'(SCALE_MUL));
               cnt_in = '0;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            num_in = {21'd0, num_ff[31:0] + 32'(qprod[41:RECIP_SHIFT])};
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            z_in = $signed({num_ff[31], num_ff[31:0]});
            neg_in = 1'b0;
            if ($signed(num_ff[31:0]) > 32'sh40000000) begin
               z_in = $signed({num_ff[31], num_ff[31:0]}) - 33'sh80000000; neg_in = 1'b1;
            end else if ($signed(num_ff[31:0]) < -32'sh40000000) begin
               z_in = $signed({num_ff[31], num_ff[31:0]}) + 33'sh80000000; neg_in = 1'b1;
            end
            state_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            if (cnt_ff != 6'd63) begin cstart = 1'b1; cnt_in = 6'd63; end
            if (cdone) begin c_ld = 1'b1; state_in = ST_ROUND; end
         end
         ST_ROUND: state_in = ST_BUILD;
         ST_BUILD: state_in = ST_MAC;
         ST_MAC: begin
            if (cmd_ff == CMD_TRANSFORM) begin
               ma = 34'(m_ff[{2'd0, i_row} * 4'd3 + {2'd0, k_ff}]);
               mb = 34'(vec_ff[k_ff]);
            end else begin
               ma = 34'(r_ff[{2'd0, i_row} * 4'd3 + {2'd0, k_ff}]);
               mb = 34'(m_ff[{2'd0, k_ff} * 4'd3 + {2'd0, j_col}]);
            end
            mctl.start = 1'b1;
            k_in = (k_ff == 2'd2) ? 2'd0 : k_ff + 2'd1;
            if (k_ff == 2'd2) begin wait_in = 3'd2; state_in = ST_STORE; end
         end
         ST_STORE: begin
            wait_in = wait_ff - 3'd1;
            if (wait_ff == 3'd0) begin
               acc_ok = 1'b1;
               mctl.clear = 1'b1;
               if ((cmd_ff == CMD_TRANSFORM && el_ff == 4'd6) ||
                   (cmd_ff != CMD_TRANSFORM && el_ff == 4'd8)) begin
                  state_in = ST_OUT;
               end else begin
                  el_in = (cmd_ff == CMD_TRANSFORM) ? el_ff + 4'd3 : el_ff + 4'd1;
                  state_in = ST_MAC;
               end
            end
         end
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff <= 1'b0;
         cnt_ff <= '0;
         for (int i = 0; i < 9; i++)
            m_ff[i] <= (i % 4 == 0) ? EW'(1 << FRAC_BITS) : '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         if (state_ff == ST_IDLE && req_tvalid && req_tready) begin
            for (int i = 0; i < 3; i++) out_ff[i] <= '0;
            sat_ff <= 1'b0;
         end
         if (state_ff == ST_OUT) begin
            rv_ff <= 1'b1;
            if (cmd_ff == CMD_IDENT)
               for (int i = 0; i < 9; i++)
                  m_ff[i] <= (i % 4 == 0) ? EW'(1 << FRAC_BITS) : '0;
            else if (cmd_ff == CMD_ROTATE && axis_ff != 2'd3)
               for (int i = 0; i < 9; i++) m_ff[i] <= nm_ff[i];
         end else if (rv_ff && rsp_tready) rv_ff <= 1'b0;
         if (acc_ok) begin
            if (cmd_ff == CMD_TRANSFORM) begin
               out_ff[i_row] <= ov;
               if (ovf) sat_ff <= 1'b1;
            end else nm_ff[el_ff] <= ent;
         end
      end
      cmd_ff <= cmd_in; axis_ff <= axis_in; num_ff <= num_in; el_ff <= el_in;
      k_ff <= k_in; ang_ff <= ang_in; z_ff <= z_in; neg_ff <= neg_in; wait_ff <= wait_in;
      if (state_ff == ST_IDLE) begin
         vec_ff[0] <= req_tdata[53:22];
         vec_ff[1] <= req_tdata[85:54];
         vec_ff[2] <= req_tdata[117:86];
      end
      if (c_ld) begin
         c_ff <= neg_ff ? -cx : cx;
         s_ff <= neg_ff ? -cy : cy;
      end
      if (state_ff == ST_ROUND) begin
         c_ff <= CW'(sat_ent(70'((c_ff + (CW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS))));
         s_ff <= CW'(sat_ent(70'((s_ff + (CW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS))));
      end
      if (state_ff == ST_BUILD) begin
         for (int i = 0; i < 9; i++) r_ff[i] <= '0;
         unique case (axis_ff)
            2'd0: begin
               r_ff[0] <= EW'(1 << FRAC_BITS); r_ff[4] <= c_ff[EW-1:0];
               r_ff[5] <= -s_ff[EW-1:0]; r_ff[7] <= s_ff[EW-1:0]; r_ff[8] <= c_ff[EW-1:0];
            end
            2'd1: begin
               r_ff[0] <= c_ff[EW-1:0]; r_ff[2] <= s_ff[EW-1:0];
               r_ff[4] <= EW'(1 << FRAC_BITS); r_ff[6] <= -s_ff[EW-1:0];
               r_ff[8] <= c_ff[EW-1:0];
            end
            default: begin
               r_ff[0] <= c_ff[EW-1:0]; r_ff[1] <= -s_ff[EW-1:0]; r_ff[3] <= s_ff[EW-1:0];
               r_ff[4] <= c_ff[EW-1:0]; r_ff[8] <= EW'(1 << FRAC_BITS);
            end
         endcase
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {7'd0, sat_ff, out_ff[2], out_ff[1], out_ff[0]};

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == ST_IDLE)) else $error("ready outside idle");
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> !req_tready) else $error("accept while result pending");
   a_sat_transform: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && sat_ff) |-> (cmd_ff == CMD_TRANSFORM)) else $error("flag on non-transform");

endmodule
